### design/max_heap_priority_queue_macros.svh
// Assertion macros for the max-heap priority queue.
`ifndef MAX_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define MAX_HEAP_PRIORITY_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define HPQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("heap queue check failed");
// next-cycle implication
`define HPQ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("heap queue check failed");
`else
`define HPQ_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define HPQ_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### design/hpq_pkg.sv
// Shared constants and codes for the max-heap priority queue.
`default_nettype none
package hpq_pkg;
	localparam int HPQ_CAPACITY  = 64;
	localparam int HPQ_KEY_WIDTH = 32;
	localparam int HPQ_TAG_WIDTH = 16;

	// fixed port widths
	localparam int KEY_PORT_W   = 32;
	localparam int TAG_PORT_W   = 16;
	localparam int COUNT_PORT_W = 7;
	localparam int STATUS_W     = 2;

	localparam logic OP_INSERT  = 1'b0;
	localparam logic OP_EXTRACT = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} hpq_status_t;
endpackage
`default_nettype wire

### design/max_heap_priority_queue.sv
// Max-heap priority queue: entry store, sift sequencer and result register.
//
// Input channel (in_valid/in_stall) carries one request: op selects insert or
// extract; item_key (signed) and item_tag are the entry for an insert.
// Output channel (out_valid/out_stall) returns one result per request:
// status, out_key/out_tag of the extracted maximum, and count after it.
// A request is taken when valid is high and stall is low at a clock edge.
//
// Result timing: an insert result is registered straight from the request;
// an extract result first passes the read and load steps. A full insert or
// empty extract answers without a sift and touches nothing.
// Sift: each heap level takes a read step and a compare step through a
// two-read, one-write entry memory with registered read data. A sift
// moves at most 6 levels (insert) and 5 (extract) at 64 entries.
// in_stall stays high while the sequencer is busy and while a waiting result is stalled.
// Reset (arst_n low) empties the queue and drops any pending result; the
// entry memory is not cleared, since only live positions are ever used.
// A stalled result holds its value until taken.
`default_nettype none
`include "max_heap_priority_queue_macros.svh"
module max_heap_priority_queue
	import hpq_pkg::*;
#(
	parameter int CAPACITY  = HPQ_CAPACITY,
	parameter int KEY_WIDTH = HPQ_KEY_WIDTH,
	parameter int TAG_WIDTH = HPQ_TAG_WIDTH
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_stall,
	input  wire                            op,
	input  wire  signed [KEY_PORT_W-1:0]   item_key,
	input  wire         [TAG_PORT_W-1:0]   item_tag,
	output logic                           out_valid,
	input  wire                            out_stall,
	output logic        [STATUS_W-1:0]     status,
	output logic signed [KEY_PORT_W-1:0]   out_key,
	output logic        [TAG_PORT_W-1:0]   out_tag,
	output logic        [COUNT_PORT_W-1:0] count
);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1; // memory address
	localparam int CW = $clog2(CAPACITY + 1);                  // count / position
	localparam int EW = KEY_WIDTH + TAG_WIDTH;
	localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
	localparam logic [CW-1:0] POS_ROOT = CW'(1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UP_RD,
		ST_UP_CMP,
		ST_EX_RD,
		ST_EX_LOAD,
		ST_DN_RD,
		ST_DN_CMP
	} state_t;

	state_t state_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] pos_q;      // 1-based hole position
	logic [EW-1:0] moving_q;   // entry being sifted
	logic          out_valid_q;
	logic [STATUS_W-1:0]   status_q;
	logic [KEY_PORT_W-1:0] out_key_q;
	logic [TAG_PORT_W-1:0] out_tag_q;
	logic [COUNT_PORT_W-1:0] count_q;

	// entry memory
	logic [EW-1:0] mem [CAPACITY];
	logic [EW-1:0] rdata_a_q, rdata_b_q;
	logic [AW-1:0] raddr_a, raddr_b, waddr;
	logic [EW-1:0] wdata;
	logic          we;

	logic          in_accept;
	logic          post_result;
	logic [AW-1:0] hole_addr, parent_addr, l_addr, r_addr;
	logic [CW:0]   lpos, rpos, cnt_ext;
	logic          l_out, r_ok, r_sel, up_move, dn_move;
	logic [EW-1:0] child_entry;
	logic [CW:0]   child_pos;
	logic signed [KEY_WIDTH-1:0] moving_key, left_key, right_key, child_key, parent_key;

	assign in_accept = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE) || (out_valid_q && out_stall);

	// a result is posted this cycle: every taken request but a non-empty
	// extract answers at once, that one answers at the load step
	assign post_result = (state_q == ST_EX_LOAD) ||
		((state_q == ST_IDLE) && in_accept && !((op == OP_EXTRACT) && (cnt_q != '0)));

	// heap navigation
	assign hole_addr   = AW'(pos_q - POS_ROOT);
	assign parent_addr = AW'((pos_q >> 1) - POS_ROOT);
	assign lpos        = {pos_q, 1'b0};
	assign rpos        = {pos_q, 1'b1};
	assign cnt_ext     = {1'b0, cnt_q};
	assign l_addr      = AW'(lpos - (CW+1)'(1));
	assign r_addr      = AW'(lpos);
	assign l_out       = lpos > cnt_ext;
	assign r_ok        = rpos <= cnt_ext;

	// compare paths on keys: child select, sift-up and sift-down
	assign moving_key  = $signed(moving_q[EW-1:TAG_WIDTH]);
	assign parent_key  = $signed(rdata_a_q[EW-1:TAG_WIDTH]);
	assign left_key    = $signed(rdata_a_q[EW-1:TAG_WIDTH]);
	assign right_key   = $signed(rdata_b_q[EW-1:TAG_WIDTH]);
	assign r_sel       = r_ok && (right_key > left_key);   // left wins ties
	assign child_entry = r_sel ? rdata_b_q : rdata_a_q;
	assign child_key   = r_sel ? right_key : left_key;
	assign child_pos   = r_sel ? rpos : lpos;
	assign up_move     = moving_key > parent_key;
	assign dn_move     = moving_key < child_key;

	always_comb begin
		raddr_a = '0;
		raddr_b = '0;
		we      = 1'b0;
		waddr   = hole_addr;
		wdata   = moving_q;
		unique case (state_q)
			ST_UP_RD: begin
				raddr_a = parent_addr;
				if (pos_q == POS_ROOT)
					we = 1'b1;
			end
			ST_UP_CMP: begin
				we = 1'b1;
				if (up_move)
					wdata = rdata_a_q;   // parent moves down into hole
			end
			ST_EX_RD: begin
				raddr_a = '0;
				raddr_b = AW'(cnt_q);    // last entry, count already decremented
			end
			ST_DN_RD: begin
				raddr_a = l_addr;
				raddr_b = r_addr;
				if (l_out)
					we = 1'b1;
			end
			ST_DN_CMP: begin
				we = 1'b1;
				if (dn_move)
					wdata = child_entry; // child moves up into hole
			end
			ST_IDLE, ST_EX_LOAD: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_a_q <= mem[raddr_a];
		rdata_b_q <= mem[raddr_b];
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			pos_q       <= '0;
			moving_q    <= '0;
			out_valid_q <= 1'b0;
			status_q    <= STATUS_OK;
			out_key_q   <= '0;
			out_tag_q   <= '0;
			count_q     <= '0;
		end else begin
			if (out_valid_q && !out_stall && !post_result)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						out_key_q <= '0;
						out_tag_q <= '0;
						if (op == OP_INSERT) begin
							if (cnt_q >= CAP_CNT) begin
								out_valid_q <= 1'b1;
								status_q    <= STATUS_FULL;
								count_q     <= COUNT_PORT_W'(cnt_q);
							end else begin
								cnt_q       <= cnt_q + CW'(1);
								pos_q       <= cnt_q + CW'(1);
								moving_q    <= {KEY_WIDTH'(item_key), TAG_WIDTH'(item_tag)};
								out_valid_q <= 1'b1;
								status_q    <= STATUS_OK;
								count_q     <= COUNT_PORT_W'(cnt_q + CW'(1));
								state_q     <= ST_UP_RD;
							end
						end else if (cnt_q == '0) begin
							out_valid_q <= 1'b1;
							status_q    <= STATUS_EMPTY;
							count_q     <= '0;
						end else begin
							cnt_q   <= cnt_q - CW'(1);
							state_q <= ST_EX_RD;
						end
					end
				end
				ST_UP_RD: begin
					state_q <= (pos_q == POS_ROOT) ? ST_IDLE : ST_UP_CMP;
				end
				ST_UP_CMP: begin
					if (up_move) begin
						pos_q   <= pos_q >> 1;
						state_q <= ST_UP_RD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EX_RD: begin
					state_q <= ST_EX_LOAD;
				end
				ST_EX_LOAD: begin
					moving_q    <= rdata_b_q;
					pos_q       <= POS_ROOT;
					out_valid_q <= 1'b1;
					status_q    <= STATUS_OK;
					out_key_q   <= KEY_PORT_W'(rdata_a_q[EW-1:TAG_WIDTH]);
					out_tag_q   <= TAG_PORT_W'(rdata_a_q[TAG_WIDTH-1:0]);
					count_q     <= COUNT_PORT_W'(cnt_q);
					state_q     <= ST_DN_RD;
				end
				ST_DN_RD: begin
					state_q <= l_out ? ST_IDLE : ST_DN_CMP;
				end
				ST_DN_CMP: begin
					if (dn_move) begin
						pos_q   <= CW'(child_pos);
						state_q <= ST_DN_RD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign out_key   = out_key_q;
	assign out_tag   = out_tag_q;
	assign count     = count_q;

	// occupancy never passes capacity
	`HPQ_ASSERT_IMP(a_cnt_cap, clk, arst_n, 1'b1, cnt_q <= CAP_CNT)
	// entry memory is only written by the sequencer while busy
	`HPQ_ASSERT_IMP(a_we_busy, clk, arst_n, we, state_q != ST_IDLE)
	// a good insert posts its result right away
	`HPQ_ASSERT_NXT(a_ins_result, clk, arst_n,
		in_accept && (op == OP_INSERT) && (cnt_q < CAP_CNT), out_valid_q && (status_q == STATUS_OK))
	// an extract of a non-empty heap posts its result at the load step
	`HPQ_ASSERT_NXT(a_ext_result, clk, arst_n, state_q == ST_EX_LOAD, out_valid_q)
endmodule
`default_nettype wire
